/* src/itrt_pkg.sv */
// Shared types, codes and the digit character function for the radix text converter.
`timescale 1ns / 1ps
package itrt_pkg;

  localparam int VALUE_W  = 64;
  localparam int DIV_BITS = 8;                    // quotient bits resolved per cycle
  localparam int DIV_STEPS = VALUE_W / DIV_BITS;  // division steps per digit
  localparam int STEP_W   = $clog2(DIV_STEPS);

  localparam logic [1:0] CMD_UDEC  = 2'd0;
  localparam logic [1:0] CMD_SDEC  = 2'd1;
  localparam logic [1:0] CMD_RADIX = 2'd2;
  localparam logic [1:0] CMD_NONE  = 2'd3;

  localparam logic [4:0] BASE_MIN = 5'd2;
  localparam logic [4:0] BASE_MAX = 5'd16;
  localparam logic [4:0] BASE_DEC = 5'd10;
  localparam logic [4:0] RADIX_RST = 5'd16;

  localparam logic [6:0] CH_MINUS = 7'h2D;

  typedef struct packed {
    logic load;        // latch a new value and set up the division
    logic div_step;    // resolve DIV_BITS quotient bits
    logic digit_wr;    // store the remainder as the next digit
    logic rd;          // fetch the next digit, most significant first
    logic emit_sign;   // present a minus sign
    logic emit_digit;  // present the fetched digit
    logic emit_last;   // the presented digit ends the number
  } itrt_cmd_t;

  typedef struct packed {
    logic q_zero;      // working quotient is zero
    logic cnt_last;    // the next stored digit fills the store
    logic cnt_zero;    // no digits left to fetch
    logic neg;         // a minus sign precedes the digits
  } itrt_stat_t;

  function automatic logic [6:0] digit_char(input logic [3:0] d);
    logic [6:0] c;
    if (d < 4'd10) begin
      c = 7'h30 + {3'b000, d};
    end else begin
      c = 7'h37 + {3'b000, d};
    end
    return c;
  endfunction

endpackage

/* src/itrt_ram.sv */
// Generic single write port, single read port RAM with registered read data.
`timescale 1ns / 1ps
module itrt_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* src/itrt_ctrl.sv */
// Sequencing state machine: divide digit by digit, then emit sign and digits.
`timescale 1ns / 1ps
module itrt_ctrl import itrt_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  logic [1:0] in_cmd,
  input  itrt_stat_t stat,
  output itrt_cmd_t  ctl,
  output logic       busy
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_STORE,
    S_SIGN,
    S_EMIT
  } state_t;

  state_t            state_r, state_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic              busy_r;

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    ctl       = '0;
    case (state_r)
      S_IDLE: begin
        if (start && in_cmd != CMD_NONE) begin
          ctl.load  = 1'b1;
          step_nxt  = '0;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        ctl.div_step = 1'b1;
        step_nxt     = step_r + 1'b1;
        if (step_r == STEP_W'(DIV_STEPS - 1)) begin
          state_nxt = S_STORE;
        end
      end
      S_STORE: begin
        ctl.digit_wr = 1'b1;
        if (stat.q_zero || stat.cnt_last) begin
          state_nxt = S_SIGN;
        end else begin
          state_nxt = S_DIV;
        end
      end
      S_SIGN: begin
        ctl.emit_sign = stat.neg;
        ctl.rd        = 1'b1;
        state_nxt     = S_EMIT;
      end
      S_EMIT: begin
        ctl.emit_digit = 1'b1;
        ctl.emit_last  = stat.cnt_zero;
        if (stat.cnt_zero) begin
          state_nxt = S_IDLE;
        end else begin
          ctl.rd = 1'b1;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      step_r  <= '0;
      busy_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      busy_r  <= (state_nxt != S_IDLE);
    end
  end

  assign busy = busy_r;

endmodule

/* src/itrt_dp.sv */
// Datapath: magnitude, shared digit divider, digit store and output register.
`timescale 1ns / 1ps
module itrt_dp import itrt_pkg::*; #(
  parameter int MAX_DIGITS = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_valid,
  input  logic [4:0]         cfg_radix,
  input  logic [1:0]         in_cmd,
  input  logic               in_wide,
  input  logic [VALUE_W-1:0] in_value,
  input  itrt_cmd_t          ctl,
  output itrt_stat_t         stat,
  output logic               out_valid,
  output logic [6:0]         out_character,
  output logic               out_last
);

  localparam int ADDR_W = $clog2(MAX_DIGITS);
  localparam int CNT_W  = $clog2(MAX_DIGITS + 1);

  logic [4:0]         radix_r;
  logic [4:0]         base_r;
  logic [VALUE_W-1:0] q_r;
  logic [3:0]         rem_r;
  logic [CNT_W-1:0]   cnt_r;
  logic               neg_r;
  logic               out_valid_r;
  logic [6:0]         out_char_r;
  logic               out_last_r;

  logic [VALUE_W-1:0] mag;
  logic               neg;
  logic [4:0]         base;
  logic [VALUE_W-1:0] q_step;
  logic [3:0]         rem_step;
  logic [CNT_W-1:0]   cnt_dec;
  logic [3:0]         rd_data;

  // Magnitude and sign of the incoming value.
  always_comb begin
    neg = 1'b0;
    if (!in_wide) begin
      mag = {32'd0, in_value[31:0]};
      if (in_cmd == CMD_SDEC && in_value[31]) begin
        neg = 1'b1;
        mag = {32'd0, ~in_value[31:0] + 32'd1};
      end
    end else begin
      mag = in_value;
      if (in_cmd == CMD_SDEC && in_value[VALUE_W-1]) begin
        neg = 1'b1;
        mag = ~in_value + 1'b1;
      end
    end
  end

  always_comb begin
    base = BASE_DEC;
    if (in_cmd == CMD_RADIX) begin
      if (radix_r < BASE_MIN) begin
        base = BASE_MIN;
      end else if (radix_r > BASE_MAX) begin
        base = BASE_MAX;
      end else begin
        base = radix_r;
      end
    end
  end

  // Restoring division, DIV_BITS quotient bits per cycle.
  always_comb begin
    logic [4:0] t;
    q_step   = q_r;
    rem_step = rem_r;
    for (int i = 0; i < DIV_BITS; i++) begin
      t      = {rem_step, q_step[VALUE_W-1]};
      q_step = {q_step[VALUE_W-2:0], 1'b0};
      if (t >= base_r) begin
        rem_step  = 4'(t - base_r);
        q_step[0] = 1'b1;
      end else begin
        rem_step = t[3:0];
      end
    end
  end

  assign cnt_dec = cnt_r - 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radix_r     <= RADIX_RST;
      q_r         <= '0;
      cnt_r       <= '0;
      neg_r       <= 1'b0;
      rem_r       <= '0;
      base_r      <= BASE_DEC;
      out_valid_r <= 1'b0;
      out_last_r  <= 1'b0;
    end else begin
      if (cfg_valid) begin
        radix_r <= cfg_radix;
      end
      if (ctl.load) begin
        q_r    <= mag;
        neg_r  <= neg;
        base_r <= base;
        rem_r  <= '0;
        cnt_r  <= '0;
      end else if (ctl.div_step) begin
        q_r   <= q_step;
        rem_r <= rem_step;
      end else if (ctl.digit_wr) begin
        rem_r <= '0;
        cnt_r <= cnt_r + 1'b1;
      end else if (ctl.rd) begin
        cnt_r <= cnt_dec;
      end
      out_valid_r <= ctl.emit_sign | ctl.emit_digit;
      out_last_r  <= ctl.emit_digit & ctl.emit_last;
    end
  end

  always_ff @(posedge clk) begin
    out_char_r <= ctl.emit_sign ? CH_MINUS : digit_char(rd_data);
  end

  itrt_ram #(
    .WIDTH (4),
    .DEPTH (MAX_DIGITS)
  ) u_store (
    .clk     (clk),
    .wr_en   (ctl.digit_wr),
    .wr_addr (cnt_r[ADDR_W-1:0]),
    .wr_data (rem_r),
    .rd_en   (ctl.rd),
    .rd_addr (cnt_dec[ADDR_W-1:0]),
    .rd_data (rd_data)
  );

  assign stat.q_zero   = (q_r == '0);
  assign stat.cnt_last = (cnt_r == CNT_W'(MAX_DIGITS - 1));
  assign stat.cnt_zero = (cnt_r == '0);
  assign stat.neg      = neg_r;

  assign out_valid     = out_valid_r;
  assign out_character = out_char_r;
  assign out_last      = out_last_r;

endmodule

/* src/integer_to_radix_text.sv */
// Top level of the integer to radix text converter.
`timescale 1ns / 1ps
// Converts one 32- or 64-bit integer per transaction into ASCII text, most
// significant character first. in_cmd selects unsigned decimal, signed decimal
// (leading '-' when negative) or unsigned in the radix held in the
// configuration register (2 to 16, out-of-range values clamp; reset 16). A
// transaction is taken when start is high and busy is low; a transaction with
// the unused command code is dropped and produces no characters. Characters
// come out on out_character, one per cycle marked by out_valid, with out_last
// on the final one; they cannot be held off, so sample every strobe. The
// digits are produced by one shared divider that resolves 8 quotient bits per
// cycle; each digit is divided and then stored into the digit RAM, and the
// text then drains at one character per cycle out of that RAM. Write the
// radix only while busy is low; cfg_ready is always high.
module integer_to_radix_text import itrt_pkg::*; #(
  parameter int MAX_DIGITS = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  // command channel
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         in_cmd,
  input  logic               in_wide,
  input  logic [VALUE_W-1:0] in_value,
  // character stream
  output logic               out_valid,
  output logic [6:0]         out_character,
  output logic               out_last,
  // radix register write
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [4:0]         cfg_radix
);

  itrt_cmd_t  ctl;
  itrt_stat_t stat;

  // Register writes are always taken; the user must write only while idle, which the block itself does not enforce.
  assign cfg_ready = 1'b1;

  // Controller: sequences divide, store and drain.
  itrt_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .in_cmd (in_cmd),
    .stat   (stat),
    .ctl    (ctl),
    .busy   (busy)
  );

  // Datapath: magnitude, divider, digit store, output register.
  itrt_dp #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_valid     (cfg_valid & cfg_ready),
    .cfg_radix     (cfg_radix),
    .in_cmd        (in_cmd),
    .in_wide       (in_wide),
    .in_value      (in_value),
    .ctl           (ctl),
    .stat          (stat),
    .out_valid     (out_valid),
    .out_character (out_character),
    .out_last      (out_last)
  );

`ifndef SYNTHESIS
  // A character only ever follows a cycle in which a transaction was in flight.
  a_out_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("character strobe without a transaction in flight");

  // The unused command is dropped without starting any work.
  a_drop_unused: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_cmd == CMD_NONE) |=> !busy)
    else $error("unused command started a conversion");

  // The last character closes the stream: nothing follows on the next cycle.
  a_last_closes: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last) |=> !out_valid)
    else $error("character strobe directly after the last character");

  // At most one of load, divide step, digit store and digit fetch is commanded at a time.
  a_ctl_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    $countones({ctl.load, ctl.div_step, ctl.digit_wr, ctl.rd}) <= 1)
    else $error("conflicting datapath commands");
`endif

endmodule

/* bench/integer_to_radix_text_test.sv */
// Self-checking testbench for the integer to radix text converter.
`timescale 1ns / 1ps
module integer_to_radix_text_test;
  import itrt_pkg::*;

  localparam int DIGIT_LIMIT  = 64;
  localparam int CLK_HALF     = 6;
  localparam int RESET_CYCLES = 12;
  localparam int RANDOM_ITEMS = 144;
  localparam int PHASES       = 6;
  localparam int SETTLE_LIMIT = 2000;   // cycles to wait for the last characters
  localparam int REPORT_CAP   = 20;

  // One number waiting to be handed to the converter.
  typedef struct {
    logic [1:0]  cmd;
    logic        wide;
    logic [63:0] value;
  } number_item_t;

  // One character that the converter should emit.
  typedef struct {
    logic [6:0] code;
    logic       last;
  } text_char_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  in_cmd = CMD_UDEC;
  logic        in_wide = 1'b0;
  logic [63:0] in_value = '0;
  logic        out_valid;
  logic [6:0]  out_character;
  logic        out_last;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [4:0]  cfg_radix = RADIX_RST;

  number_item_t pending_numbers[$];
  text_char_t   expected_text[$];

  logic [4:0] radix_setting = RADIX_RST;  // our copy of the radix register
  int idle_pct = 30;
  int mismatch_count = 0;
  int numbers_converted = 0;
  int numbers_ignored = 0;
  int chars_checked = 0;
  int radix_writes = 0;

  integer_to_radix_text #(
    .MAX_DIGITS(DIGIT_LIMIT)
  ) u_top (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_cmd       (in_cmd),
    .in_wide      (in_wide),
    .in_value     (in_value),
    .out_valid    (out_valid),
    .out_character(out_character),
    .out_last     (out_last),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_radix    (cfg_radix)
  );

  always #CLK_HALF clk = ~clk;

  // Print one line per mismatch (up to a cap) and count every one of them.
  task automatic report_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= REPORT_CAP) begin
      $display("[%0t] character check failed: %s", $realtime, what);
    end
  endtask

  // Work out the text of one accepted number and queue its characters.
  // The unused command produces nothing and leaves the state alone.
  function automatic void predict_text(input logic [1:0] cmd, input logic wide,
                                       input logic [63:0] value);
    logic [63:0] mag;
    logic [63:0] q;
    logic [63:0] base;
    logic        neg;
    logic [3:0]  digits [DIGIT_LIMIT];
    int          count;
    text_char_t  c;
    if (cmd == CMD_NONE) begin
      return;
    end
    // Clamp the configured radix into 2..16; the decimal modes ignore it.
    if (cmd == CMD_RADIX) begin
      if (radix_setting < BASE_MIN) begin
        base = 64'(BASE_MIN);
      end else if (radix_setting > BASE_MAX) begin
        base = 64'(BASE_MAX);
      end else begin
        base = 64'(radix_setting);
      end
    end else begin
      base = 64'(BASE_DEC);
    end
    neg = 1'b0;
    if (!wide) begin
      // Narrow numbers use only the low word; bit 31 is the sign.
      mag = {32'd0, value[31:0]};
      if (cmd == CMD_SDEC && value[31]) begin
        neg = 1'b1;
        mag = 64'h1_0000_0000 - mag;   // most negative comes out as 2^31
      end
    end else begin
      mag = value;
      if (cmd == CMD_SDEC && value[63]) begin
        neg = 1'b1;
        mag = -value;                  // two's complement keeps 2^63 exact
      end
    end
    // Peel digits off least significant first; zero still yields one digit.
    q = mag;
    count = 0;
    do begin
      digits[count] = 4'(q % base);
      q = q / base;
      count++;
    end while (q != 0 && count < DIGIT_LIMIT);
    if (neg) begin
      c.code = CH_MINUS;
      c.last = 1'b0;
      expected_text.push_back(c);
    end
    for (int i = count - 1; i >= 0; i--) begin
      // 0x30 is '0', 0x41 is 'A'
      c.code = (digits[i] < 4'd10) ? 7'h30 + 7'(digits[i]) : 7'h41 + 7'(digits[i]) - 7'd10;
      c.last = (i == 0);
      expected_text.push_back(c);
    end
  endfunction

  // Driver: present queued numbers on start, holding each until busy is low at
  // an edge. Idle at random between transactions when idle_pct allows it.
  always @(posedge clk) begin : number_driver
    number_item_t item;
    bit           ready_for_next;
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      ready_for_next = !start;
      if (start && !busy) begin
        predict_text(in_cmd, in_wide, in_value);
        if (in_cmd == CMD_NONE) begin
          numbers_ignored++;
        end else begin
          numbers_converted++;
        end
        ready_for_next = 1'b1;
      end
      if (ready_for_next) begin
        if (pending_numbers.size() != 0 && $urandom_range(99) >= idle_pct) begin
          item = pending_numbers.pop_front();
          start    <= 1'b1;
          in_cmd   <= item.cmd;
          in_wide  <= item.wide;
          in_value <= item.value;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: every strobe is a character; compare it with the oldest prediction.
  always @(posedge clk) begin : char_monitor
    text_char_t want;
    if (rst_n && out_valid) begin
      chars_checked++;
      if (expected_text.size() == 0) begin
        report_mismatch($sformatf("unexpected character 0x%02h last %0b",
                                  out_character, out_last));
      end else begin
        want = expected_text.pop_front();
        if (out_character !== want.code) begin
          report_mismatch($sformatf("character 0x%02h, wanted 0x%02h",
                                    out_character, want.code));
        end
        if (out_last !== want.last) begin
          report_mismatch($sformatf("last %0b on character 0x%02h, wanted %0b",
                                    out_last, out_character, want.last));
        end
      end
    end
  end

  task automatic add_number(input logic [1:0] cmd, input logic wide,
                            input logic [63:0] value);
    number_item_t item;
    item.cmd = cmd;
    item.wide = wide;
    item.value = value;
    pending_numbers.push_back(item);
  endtask

  // Hold the sender until every queued transaction is taken, every predicted
  // character has arrived and the converter has gone idle again.
  task automatic drain_text();
    int waited;
    while (pending_numbers.size() != 0 || start) begin
      @(posedge clk);
    end
    repeat (4) @(posedge clk);
    waited = 0;
    while ((expected_text.size() != 0 || busy) && waited < SETTLE_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (expected_text.size() != 0) begin
      report_mismatch($sformatf("%0d characters never arrived", expected_text.size()));
      expected_text.delete();
    end
    repeat (8) @(posedge clk);
  endtask

  // Write the radix register; only called while the converter is idle.
  task automatic write_radix(input logic [4:0] r);
    cfg_valid <= 1'b1;
    cfg_radix <= r;
    do begin
      @(posedge clk);
    end while (!cfg_ready);
    radix_setting = r;
    radix_writes++;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Mix of edge values, small numbers, powers of ten either side and raw noise.
  function automatic logic [63:0] pick_value();
    logic [63:0] v;
    int          k;
    case ($urandom_range(9))
      0: v = '0;
      1: v = '1;
      2: v = 64'h8000_0000_0000_0000 + 64'($urandom_range(2)) - 64'd1;
      3: v = {$urandom, 32'h8000_0000 + 32'($urandom_range(2)) - 32'd1};
      4, 5: v = {$urandom, $urandom} >> $urandom_range(63);
      6: begin
        v = 64'd1;
        k = $urandom_range(19);
        for (int i = 0; i < k; i++) begin
          v = v * 64'd10;
        end
        v = v + 64'($urandom_range(2)) - 64'd1;
      end
      default: v = {$urandom, $urandom};
    endcase
    return v;
  endfunction

  function automatic logic [1:0] pick_cmd();
    logic [1:0] cmd;
    case ($urandom_range(19))
      0:             cmd = CMD_NONE;
      1, 2, 3, 4, 5, 6: cmd = CMD_UDEC;
      7, 8, 9, 10, 11, 12: cmd = CMD_SDEC;
      default:       cmd = CMD_RADIX;
    endcase
    return cmd;
  endfunction

  initial begin : stimulus
    logic [4:0] phase_radix [PHASES];
    logic [1:0] cmd;
    int         counted;
    phase_radix = '{5'd2, 5'd31, 5'd10, 5'd0, 5'd17, 5'd7};
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // Directed: decimal extremes, narrow sign boundary, ignored command and
    // the reset radix, before the register is touched.
    add_number(CMD_UDEC,  1'b0, 64'd0);
    add_number(CMD_UDEC,  1'b0, 64'hFFFF_FFFF_FFFF_FFFF);   // upper word ignored
    add_number(CMD_UDEC,  1'b1, 64'hFFFF_FFFF_FFFF_FFFF);   // twenty digits
    add_number(CMD_SDEC,  1'b0, 64'h0000_0000_8000_0000);   // -2147483648
    add_number(CMD_SDEC,  1'b0, 64'h1234_5678_FFFF_FFFF);   // -1, junk above
    add_number(CMD_SDEC,  1'b0, 64'hFFFF_FFFF_7FFF_FFFF);   // largest positive
    add_number(CMD_SDEC,  1'b1, 64'h8000_0000_0000_0000);   // most negative
    add_number(CMD_SDEC,  1'b1, 64'hFFFF_FFFF_FFFF_FFFF);
    add_number(CMD_SDEC,  1'b1, 64'h7FFF_FFFF_FFFF_FFFF);
    add_number(CMD_SDEC,  1'b1, 64'd0);
    add_number(CMD_NONE,  1'b1, 64'h0123_4567_89AB_CDEF);
    add_number(CMD_RADIX, 1'b1, 64'hFEDC_BA98_7654_3210);
    add_number(CMD_RADIX, 1'b0, 64'h0000_0000_0000_0000);
    add_number(CMD_UDEC,  1'b1, 64'd10_000_000_000_000_000_000 - 64'd1);
    drain_text();

    // Radix extremes: binary gives the longest text; 0 and 1 act as 2,
    // anything above 16 acts as 16.
    write_radix(BASE_MIN);
    add_number(CMD_RADIX, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF);
    add_number(CMD_RADIX, 1'b0, 64'h0000_0001_0000_0000);
    drain_text();
    write_radix(5'd0);
    add_number(CMD_RADIX, 1'b0, 64'h0000_0000_8000_0001);
    drain_text();
    write_radix(5'd1);
    add_number(CMD_RADIX, 1'b1, 64'h5555_5555_5555_5555);
    drain_text();
    write_radix(5'd31);
    add_number(CMD_RADIX, 1'b1, 64'hA5A5_A5A5_A5A5_A5A5);
    drain_text();
    write_radix(BASE_MAX);
    add_number(CMD_RADIX, 1'b1, 64'h8000_0000_0000_0000);
    drain_text();

    // Random phases, one radix setting each; the third runs without any idling.
    for (int p = 0; p < PHASES; p++) begin
      if (p == PHASES - 1) begin
        write_radix(5'($urandom_range(31)));
      end else begin
        write_radix(phase_radix[p]);
      end
      idle_pct = (p == 2) ? 0 : 30;
      counted = 0;
      while (counted < RANDOM_ITEMS / PHASES + 1) begin
        cmd = pick_cmd();
        add_number(cmd, 1'($urandom_range(1)), pick_value());
        if (cmd != CMD_NONE) begin
          counted++;
        end
      end
      drain_text();
    end

    $display("Converted %0d numbers (%0d ignored commands dropped), %0d characters checked.",
             numbers_converted, numbers_ignored, chars_checked);
    $display("Decimal, signed and radix modes covered over %0d radix register writes.",
             radix_writes);
    if (mismatch_count == 0) begin
      $display("integer_to_radix_text: match");
    end else begin
      $display("integer_to_radix_text: mismatch");
    end
    $finish;
  end

  // Guard against a hung converter: far beyond the slowest legal run.
  initial begin : watchdog
    #(64'd800_000 * 2 * CLK_HALF);
    $display("integer_to_radix_text: mismatch");
    $finish;
  end

endmodule
